// ----- hdl/btse_pkg.sv -----
package btse_pkg;

    // Widths of the coefficient and sample fields.
    localparam int COEF_WIDTH     = 20;
    localparam int COEF_FRAC_BITS = 16;
    localparam int SAMPLE_WIDTH   = 16;

    // Packed register layouts: three feedforward and two feedback coefficients.
    localparam int FF_WIDTH       = 3 * COEF_WIDTH;
    localparam int FB_WIDTH       = 2 * COEF_WIDTH;
    localparam int CFG_DATA_WIDTH = 60;
    localparam int CFG_IDX_WIDTH  = 2;

    // Product and accumulator widths; five terms need three guard bits.
    localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + 3;
    localparam int QUOT_WIDTH = ACC_WIDTH - COEF_FRAC_BITS;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BASS_FF   = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_BASS_FB   = CFG_IDX_WIDTH'(1);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TREBLE_FF = CFG_IDX_WIDTH'(2);
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TREBLE_FB = CFG_IDX_WIDTH'(3);

    // Reset value of a feedforward register: b0 = 1.0, b1 = b2 = 0.
    localparam logic [FF_WIDTH-1:0] FF_RESET =
        {COEF_WIDTH'(1 << COEF_FRAC_BITS), {(2 * COEF_WIDTH){1'b0}}};

    // Terms of one biquad, in the order the shared unit evaluates them.
    localparam int NUM_TERMS  = 5;
    localparam int TERM_WIDTH = $clog2(NUM_TERMS);
    localparam logic [TERM_WIDTH-1:0] TERM_B0   = TERM_WIDTH'(0);
    localparam logic [TERM_WIDTH-1:0] TERM_B1   = TERM_WIDTH'(1);
    localparam logic [TERM_WIDTH-1:0] TERM_B2   = TERM_WIDTH'(2);
    localparam logic [TERM_WIDTH-1:0] TERM_FA1  = TERM_WIDTH'(3);
    localparam logic [TERM_WIDTH-1:0] TERM_FA2  = TERM_WIDTH'(4);
    localparam logic [TERM_WIDTH-1:0] TERM_LAST = TERM_FA2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_WB
    } ctrl_state_t;

    typedef enum logic {
        STAGE_BASS,
        STAGE_TREBLE
    } stage_t;

    // Controls of the shared multiply-accumulate unit.
    typedef struct packed {
        logic issue;
        logic first;
    } mac_ctrl_t;

    // Everything the sequencer tells the datapath.
    typedef struct packed {
        mac_ctrl_t                 mac;
        logic [TERM_WIDTH-1:0]     term;
        stage_t                    stage;
        logic                      wb_bass;
        logic                      wb_treble;
        logic                      busy;
    } seq_ctrl_t;

    // Divides the accumulator by 2^COEF_FRAC_BITS toward zero and saturates.
    function automatic logic signed [SAMPLE_WIDTH-1:0] stage_result(
        input logic signed [ACC_WIDTH-1:0] acc
    );
        logic signed [ACC_WIDTH-1:0]  bias;
        logic signed [ACC_WIDTH-1:0]  biased;
        logic signed [QUOT_WIDTH-1:0] quot;
        logic [QUOT_WIDTH-SAMPLE_WIDTH:0] top_bits;
        logic signed [SAMPLE_WIDTH-1:0] res;
        bias     = acc[ACC_WIDTH-1] ? ACC_WIDTH'((1 << COEF_FRAC_BITS) - 1) : '0;
        biased   = acc + bias;
        quot     = QUOT_WIDTH'(biased >>> COEF_FRAC_BITS);
        top_bits = quot[QUOT_WIDTH-1:SAMPLE_WIDTH-1];
        if ((top_bits == '0) || (top_bits == '1))
        begin
            res = quot[SAMPLE_WIDTH-1:0];
        end
        else if (quot[QUOT_WIDTH-1])
        begin
            res = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ----- hdl/btse_mac.sv -----
module btse_mac (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  btse_pkg::mac_ctrl_t                       mac_ctrl,
    input  logic signed [btse_pkg::COEF_WIDTH-1:0]    coef,
    input  logic signed [btse_pkg::SAMPLE_WIDTH-1:0]  sample,
    output logic signed [btse_pkg::ACC_WIDTH-1:0]     acc
);
    import btse_pkg::*;

    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic                         prod_valid_reg;
    logic                         prod_first_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic signed [ACC_WIDTH-1:0]  acc_next;

    // Multiplier stage: one product per cycle, registered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_first_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= mac_ctrl.issue;
            prod_first_reg <= mac_ctrl.first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_ctrl.issue)
        begin
            prod_reg <= coef * sample;
        end
    end

    // Accumulator stage: the first term of a stage restarts the sum.
    always_comb
    begin
        if (prod_first_reg)
        begin
            acc_next = ACC_WIDTH'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_WIDTH'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- hdl/btse_ctrl.sv -----
module btse_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_accept,
    input  logic                  out_free,
    output btse_pkg::seq_ctrl_t   ctrl
);
    import btse_pkg::*;

    ctrl_state_t            state_reg;
    ctrl_state_t            state_next;
    stage_t                 stage_reg;
    stage_t                 stage_next;
    logic [TERM_WIDTH-1:0]  term_reg;
    logic [TERM_WIDTH-1:0]  term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stage_reg <= STAGE_BASS;
            term_reg  <= TERM_B0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            term_reg  <= term_next;
        end
    end

    // Next state: five products, a drain, a writeback, per stage.
    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_MAC;
                    stage_next = STAGE_BASS;
                    term_next  = TERM_B0;
                end
            end
            ST_MAC:
            begin
                if (term_reg == TERM_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    term_next = term_reg + TERM_WIDTH'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (stage_reg == STAGE_BASS)
                begin
                    state_next = ST_MAC;
                    stage_next = STAGE_TREBLE;
                    term_next  = TERM_B0;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs decoded from the current state; the treble writeback also needs out_free.
    always_comb
    begin
        ctrl.mac.issue = (state_reg == ST_MAC);
        ctrl.mac.first = (state_reg == ST_MAC) && (term_reg == TERM_B0);
        ctrl.term      = term_reg;
        ctrl.stage     = stage_reg;
        ctrl.wb_bass   = (state_reg == ST_WB) && (stage_reg == STAGE_BASS);
        ctrl.wb_treble = (state_reg == ST_WB) && (stage_reg == STAGE_TREBLE) && out_free;
        ctrl.busy      = (state_reg != ST_IDLE);
    end

endmodule

// ----- hdl/bass_treble_shelf_equalizer_core.sv -----
// Channel | Signals                                  | Direction
// input   | in_valid, in_stall, in_sample, block_start | item in
// output  | out_valid, out_stall, out_sample         | item out
// config  | cfg_wr_en, cfg_index, cfg_data           | register write
//
// A new item is not accepted until the last one is done: each biquad runs
// five products through the one shared multiplier, a drain state for the
// accumulator and a writeback that rounds, saturates and writes history.
// Reset clears history, control state and loads the unity-gain coefficients.
// The finished item waits in the output register; a stalled output holds the
// block in its final writeback until the register is free.
module bass_treble_shelf_equalizer_core (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic signed [btse_pkg::SAMPLE_WIDTH-1:0]     in_sample,
    input  logic                                         block_start,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [btse_pkg::SAMPLE_WIDTH-1:0]     out_sample,
    input  logic                                         cfg_wr_en,
    input  logic [btse_pkg::CFG_IDX_WIDTH-1:0]           cfg_index,
    input  logic [btse_pkg::CFG_DATA_WIDTH-1:0]          cfg_data
);
    import btse_pkg::*;

    seq_ctrl_t                      ctrl;
    logic                           in_accept;
    logic                           out_free;

    logic [FF_WIDTH-1:0]            bass_ff_reg;
    logic [FB_WIDTH-1:0]            bass_fb_reg;
    logic [FF_WIDTH-1:0]            treble_ff_reg;
    logic [FB_WIDTH-1:0]            treble_fb_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] bass_in0_reg;
    logic signed [SAMPLE_WIDTH-1:0] bass_in1_reg;
    logic signed [SAMPLE_WIDTH-1:0] bass_out0_reg;
    logic signed [SAMPLE_WIDTH-1:0] bass_out1_reg;
    logic signed [SAMPLE_WIDTH-1:0] treble_in0_reg;
    logic signed [SAMPLE_WIDTH-1:0] treble_in1_reg;
    logic signed [SAMPLE_WIDTH-1:0] treble_out0_reg;
    logic signed [SAMPLE_WIDTH-1:0] treble_out1_reg;

    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;

    logic [FF_WIDTH-1:0]            sel_ff;
    logic [FB_WIDTH-1:0]            sel_fb;
    logic signed [COEF_WIDTH-1:0]   op_coef;
    logic signed [SAMPLE_WIDTH-1:0] op_sample;
    logic signed [ACC_WIDTH-1:0]    acc;
    logic signed [SAMPLE_WIDTH-1:0] stage_y;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = ctrl.busy;

    btse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    // Coefficient registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bass_ff_reg   <= FF_RESET;
            bass_fb_reg   <= '0;
            treble_ff_reg <= FF_RESET;
            treble_fb_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BASS_FF:   bass_ff_reg   <= FF_WIDTH'(cfg_data);
                REG_BASS_FB:   bass_fb_reg   <= FB_WIDTH'(cfg_data);
                REG_TREBLE_FF: treble_ff_reg <= FF_WIDTH'(cfg_data);
                REG_TREBLE_FB: treble_fb_reg <= FB_WIDTH'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        sel_ff = (ctrl.stage == STAGE_BASS) ? bass_ff_reg : treble_ff_reg;
        sel_fb = (ctrl.stage == STAGE_BASS) ? bass_fb_reg : treble_fb_reg;
        case (ctrl.term)
            TERM_B0:
            begin
                op_coef   = sel_ff[2 * COEF_WIDTH +: COEF_WIDTH];
                op_sample = x_reg;
            end
            TERM_B1:
            begin
                op_coef   = sel_ff[COEF_WIDTH +: COEF_WIDTH];
                op_sample = (ctrl.stage == STAGE_BASS) ? bass_in0_reg : treble_in0_reg;
            end
            TERM_B2:
            begin
                op_coef   = sel_ff[0 +: COEF_WIDTH];
                op_sample = (ctrl.stage == STAGE_BASS) ? bass_in1_reg : treble_in1_reg;
            end
            TERM_FA1:
            begin
                op_coef   = sel_fb[COEF_WIDTH +: COEF_WIDTH];
                op_sample = (ctrl.stage == STAGE_BASS) ? bass_out0_reg : treble_out0_reg;
            end
            TERM_FA2:
            begin
                op_coef   = sel_fb[0 +: COEF_WIDTH];
                op_sample = (ctrl.stage == STAGE_BASS) ? bass_out1_reg : treble_out1_reg;
            end
            default:
            begin
                op_coef   = '0;
                op_sample = '0;
            end
        endcase
    end

    btse_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .mac_ctrl (ctrl.mac),
        .coef     (op_coef),
        .sample   (op_sample),
        .acc      (acc)
    );

    // Rounding toward zero and saturation of the finished sum.
    assign stage_y = stage_result(acc);

    // Stage input: the accepted sample, then the bass result for the treble stage.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= in_sample;
        end
        else if (ctrl.wb_bass)
        begin
            x_reg <= stage_y;
        end
    end

    // History of both stages; a block start clears it before filtering.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bass_in0_reg    <= '0;
            bass_in1_reg    <= '0;
            bass_out0_reg   <= '0;
            bass_out1_reg   <= '0;
            treble_in0_reg  <= '0;
            treble_in1_reg  <= '0;
            treble_out0_reg <= '0;
            treble_out1_reg <= '0;
        end
        else if (in_accept && block_start)
        begin
            bass_in0_reg    <= '0;
            bass_in1_reg    <= '0;
            bass_out0_reg   <= '0;
            bass_out1_reg   <= '0;
            treble_in0_reg  <= '0;
            treble_in1_reg  <= '0;
            treble_out0_reg <= '0;
            treble_out1_reg <= '0;
        end
        else if (ctrl.wb_bass)
        begin
            bass_in1_reg  <= bass_in0_reg;
            bass_in0_reg  <= x_reg;
            bass_out1_reg <= bass_out0_reg;
            bass_out0_reg <= stage_y;
        end
        else if (ctrl.wb_treble)
        begin
            treble_in1_reg  <= treble_in0_reg;
            treble_in0_reg  <= x_reg;
            treble_out1_reg <= treble_out0_reg;
            treble_out0_reg <= stage_y;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.wb_treble)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wb_treble)
        begin
            out_sample_reg <= stage_y;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    // A new item starts the bass stage with its first product.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (ctrl.mac.issue && ctrl.mac.first && ctrl.stage == STAGE_BASS))
        else $error("accepted item did not start the bass stage");

    // The output register is never loaded over an item still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wb_treble |-> (!out_valid_reg || !out_stall))
        else $error("output item overwritten");

    // A result appears only after the treble writeback.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.wb_treble))
        else $error("result without treble writeback");

    // The multiplier is idle while a stage result is written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wb_bass || ctrl.wb_treble) |-> !ctrl.mac.issue)
        else $error("product issued during writeback");

endmodule
